// ----- src/weighted_random_dispatcher_assert.svh -----
// ----------------------------------------------------------------------------
// weighted random dispatcher assertion macros
// clocked on clock, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_DISPATCHER_ASSERT_SVH
`define WEIGHTED_RANDOM_DISPATCHER_ASSERT_SVH

// same-cycle implication
`define WRD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/wrd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrd_pkg
// shared constants, microcode types and the control store of the dispatcher
// ----------------------------------------------------------------------------
package wrd_pkg;

   localparam int MAX_RECEIVERS_DEF = 16;
   localparam int WEIGHT_W          = 17;
   localparam int DRAW_W            = 7;
   localparam int INDEX_OUT_W       = 4;
   localparam int COUNT_OUT_W       = 5;
   localparam int DIV_STEPS         = 17;
   localparam int BIT_CNT_W         = 5;
   localparam int UPC_W             = 5;

   localparam logic [WEIGHT_W-1:0]  Q_ONE      = 17'h10000;
   localparam logic [6:0]           DRAW_SCALE = 7'd100;
   localparam logic [BIT_CNT_W-1:0] DIV_LAST   = 5'(DIV_STEPS - 1);

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_PICK = 1'b1;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_WSEL,
      ACT_DIV,
      ACT_DIVEND,
      ACT_RD,
      ACT_MUL,
      ACT_WRSCALE,
      ACT_APPEND,
      ACT_REJECT,
      ACT_ACC,
      ACT_CMP,
      ACT_RESP
   } act_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_ACCEPT,
      C_PICK,
      C_FULL,
      C_WT_OK,
      C_DIV_MORE,
      C_IDX_END,
      C_HIT,
      C_OUT_FREE
   } cond_sel_type;

   typedef struct packed {
      act_type          act;
      cond_sel_type     cond;
      logic [UPC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic no_accept;
      logic pick;
      logic full;
      logic wt_ok;
      logic div_more;
      logic idx_end;
      logic hit;
      logic out_free;
   } flags_type;

   // control store addresses
   localparam logic [UPC_W-1:0] U_IDLE     = 5'd0;
   localparam logic [UPC_W-1:0] U_DISPATCH = 5'd1;
   localparam logic [UPC_W-1:0] U_ADDCHK   = 5'd2;
   localparam logic [UPC_W-1:0] U_WSEL     = 5'd3;
   localparam logic [UPC_W-1:0] U_DIV      = 5'd4;
   localparam logic [UPC_W-1:0] U_DIVEND   = 5'd5;
   localparam logic [UPC_W-1:0] U_SCHK     = 5'd6;
   localparam logic [UPC_W-1:0] U_SRD      = 5'd7;
   localparam logic [UPC_W-1:0] U_SMUL     = 5'd8;
   localparam logic [UPC_W-1:0] U_SWR      = 5'd9;
   localparam logic [UPC_W-1:0] U_APPEND   = 5'd10;
   localparam logic [UPC_W-1:0] U_REJECT   = 5'd11;
   localparam logic [UPC_W-1:0] U_RESP     = 5'd12;
   localparam logic [UPC_W-1:0] U_RWAIT    = 5'd13;
   localparam logic [UPC_W-1:0] U_PSTART   = 5'd14;
   localparam logic [UPC_W-1:0] U_PRD      = 5'd15;
   localparam logic [UPC_W-1:0] U_PACC     = 5'd16;
   localparam logic [UPC_W-1:0] U_PCMP     = 5'd17;
   localparam logic [UPC_W-1:0] U_PNEXT    = 5'd18;

   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucode_type w;
      case (addr)
         U_IDLE:     w = '{ACT_LOAD,    C_NO_ACCEPT, U_IDLE};
         U_DISPATCH: w = '{ACT_NONE,    C_PICK,      U_PSTART};
         U_ADDCHK:   w = '{ACT_NONE,    C_FULL,      U_REJECT};
         U_WSEL:     w = '{ACT_WSEL,    C_WT_OK,     U_SCHK};
         U_DIV:      w = '{ACT_DIV,     C_DIV_MORE,  U_DIV};
         U_DIVEND:   w = '{ACT_DIVEND,  C_NEVER,     U_IDLE};
         U_SCHK:     w = '{ACT_NONE,    C_IDX_END,   U_APPEND};
         U_SRD:      w = '{ACT_RD,      C_NEVER,     U_IDLE};
         U_SMUL:     w = '{ACT_MUL,     C_NEVER,     U_IDLE};
         U_SWR:      w = '{ACT_WRSCALE, C_ALWAYS,    U_SCHK};
         U_APPEND:   w = '{ACT_APPEND,  C_ALWAYS,    U_RESP};
         U_REJECT:   w = '{ACT_REJECT,  C_NEVER,     U_IDLE};
         U_RESP:     w = '{ACT_RESP,    C_OUT_FREE,  U_IDLE};
         U_RWAIT:    w = '{ACT_NONE,    C_ALWAYS,    U_RESP};
         U_PSTART:   w = '{ACT_NONE,    C_IDX_END,   U_RESP};
         U_PRD:      w = '{ACT_RD,      C_NEVER,     U_IDLE};
         U_PACC:     w = '{ACT_ACC,     C_NEVER,     U_IDLE};
         U_PCMP:     w = '{ACT_CMP,     C_HIT,       U_RESP};
         U_PNEXT:    w = '{ACT_NONE,    C_ALWAYS,    U_PSTART};
         default:    w = '{ACT_NONE,    C_ALWAYS,    U_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ----- src/weighted_random_dispatcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_random_dispatcher
// roulette wheel selection over a table of Q1.16 receiver weights
// ----------------------------------------------------------------------------
// req_ channel: cmd 0 appends a receiver with new_weight (above 1.0 gives the
// default 1/(n+1)), rescaling the earlier weights by (1 - w); cmd 1 draws a
// receiver with rand_value (0..99) against the running weight sum.
// rsp_ channel: one beat per request with chosen_index, found,
// receiver_count and rejected (add to a full table).
// One request is worked at a time by a microprogram; req_ready is high only
// while the program waits at its idle step, from the cycle after the result loads.
// Add: the program rescales each existing receiver by a weight memory read, a
// multiply and a write, after the default weight divider (one quotient bit a
// cycle) when new_weight is above 1.0; a rejected add goes straight to the
// result. Pick: each entry costs a weight memory read, an accumulate and a
// compare, until one matches or the receivers run out.
// Reset empties the table; weights need no clearing since only entries below
// the count are ever read.
// The result sits in an output register: a stalled receiver holds the beat
// while the next request is taken; a second result waits in the program.
// ----------------------------------------------------------------------------
module weighted_random_dispatcher import wrd_pkg::*; #(
   parameter int MAX_RECEIVERS = MAX_RECEIVERS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [WEIGHT_W-1:0]    req_new_weight,
   input  logic [DRAW_W-1:0]      req_rand_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [INDEX_OUT_W-1:0] rsp_chosen_index,
   output logic                   rsp_found,
   output logic [COUNT_OUT_W-1:0] rsp_receiver_count,
   output logic                   rsp_rejected
);

   localparam int AW = $clog2(MAX_RECEIVERS);
   localparam int CW = $clog2(MAX_RECEIVERS + 1);
   localparam int SW = WEIGHT_W + AW;
   localparam int MW = SW + DRAW_W;
   localparam int PW = 2 * WEIGHT_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_RECEIVERS);

   ucode_type ctrl;
   flags_type flags;

   logic                cmd_ff,   cmd_in;
   logic [WEIGHT_W-1:0] wt_ff,    wt_in;
   logic [DRAW_W-1:0]   draw_ff,  draw_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff,   idx_in;
   logic [SW-1:0]       acc_ff,   acc_in;
   logic [WEIGHT_W-1:0] w_ff,     w_in;
   logic [WEIGHT_W-1:0] q_ff,     q_in;
   logic [CW:0]         rem_ff,   rem_in;
   logic [BIT_CNT_W-1:0] bit_ff,  bit_in;
   logic [PW-1:0]       prod_ff,  prod_in;
   logic [AW-1:0]       res_idx_ff,   res_idx_in;
   logic                res_found_ff, res_found_in;
   logic                res_rej_ff,   res_rej_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_OUT_W-1:0] rsp_idx_ff,   rsp_idx_in;
   logic                rsp_found_ff,    rsp_found_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                rsp_rej_ff,      rsp_rej_in;

   logic                req_fire;
   logic                out_busy;
   logic [CW:0]         divisor;
   logic [CW:0]         rem_sh;
   logic                rem_ge;
   logic [WEIGHT_W-1:0] one_minus_w;
   logic [MW-1:0]       lhs;
   logic [MW-1:0]       rhs;
   logic                hit;
   logic [AW+INDEX_OUT_W-1:0] idx_wide;
   logic [CW+COUNT_OUT_W-1:0] count_wide;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [WEIGHT_W-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [WEIGHT_W-1:0] ram_rd_data;

   wrd_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   wrd_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (MAX_RECEIVERS)
   ) u_weights (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (ctrl.act == ACT_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign out_busy  = rsp_valid_ff && !rsp_ready;

   // restoring divide of 1.0 by count + 1, one quotient bit a step
   assign divisor = (CW + 1)'(count_ff) + 1'b1;
   assign rem_sh  = {rem_ff[CW-1:0], q_ff[WEIGHT_W-1]};
   assign rem_ge  = (rem_sh >= divisor);

   assign one_minus_w = Q_ONE - w_ff;

   // draw * 1.0 against running sum * 100
   assign lhs = MW'({draw_ff, 16'h0000});
   assign rhs = MW'(acc_ff) * MW'(DRAW_SCALE);
   assign hit = (lhs <= rhs);

   always_comb begin
      flags.no_accept = !req_fire;
      flags.pick      = (cmd_ff == CMD_PICK);
      flags.full      = (count_ff == FULL_COUNT);
      flags.wt_ok     = (wt_ff <= Q_ONE);
      flags.div_more  = (bit_ff != DIV_LAST);
      flags.idx_end   = (idx_ff == count_ff);
      flags.hit       = hit;
      flags.out_free  = !out_busy;
   end

   always_comb begin
      cmd_in       = cmd_ff;
      wt_in        = wt_ff;
      draw_in      = draw_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      w_in         = w_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      prod_in      = prod_ff;
      res_idx_in   = res_idx_ff;
      res_found_in = res_found_ff;
      res_rej_in   = res_rej_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_valid_in = out_busy;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff[AW-1:0];
      ram_wr_data  = prod_ff[WEIGHT_W+15:16];
      ram_rd_en    = 1'b0;
      idx_wide     = {{INDEX_OUT_W{1'b0}}, res_idx_ff};
      count_wide   = {{COUNT_OUT_W{1'b0}}, count_ff};

      case (ctrl.act)
         ACT_LOAD: begin
            if (req_fire) begin
               cmd_in       = req_cmd;
               wt_in        = req_new_weight;
               draw_in      = req_rand_value;
               idx_in       = '0;
               acc_in       = '0;
               res_idx_in   = '0;
               res_found_in = 1'b0;
               res_rej_in   = 1'b0;
            end
         end
         ACT_WSEL: begin
            w_in   = wt_ff;
            q_in   = Q_ONE;
            rem_in = '0;
            bit_in = '0;
         end
         ACT_DIV: begin
            rem_in = rem_ge ? rem_sh - divisor : rem_sh;
            q_in   = {q_ff[WEIGHT_W-2:0], rem_ge};
            bit_in = bit_ff + 1'b1;
         end
         ACT_DIVEND: begin
            w_in = q_ff;
         end
         ACT_RD: begin
            ram_rd_en = 1'b1;
         end
         ACT_MUL: begin
            prod_in = PW'(ram_rd_data) * PW'(one_minus_w);
         end
         ACT_WRSCALE: begin
            ram_wr_en = 1'b1;
            idx_in    = idx_ff + 1'b1;
         end
         ACT_APPEND: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = count_ff[AW-1:0];
            ram_wr_data = w_ff;
            count_in    = count_ff + 1'b1;
         end
         ACT_REJECT: begin
            res_rej_in = 1'b1;
         end
         ACT_ACC: begin
            acc_in = acc_ff + SW'(ram_rd_data);
         end
         ACT_CMP: begin
            if (hit) begin
               res_found_in = 1'b1;
               res_idx_in   = idx_ff[AW-1:0];
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ACT_RESP: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_wide[INDEX_OUT_W-1:0];
               rsp_found_in = res_found_ff;
               rsp_count_in = count_wide[COUNT_OUT_W-1:0];
               rsp_rej_in   = res_rej_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      wt_ff        <= wt_in;
      draw_ff      <= draw_in;
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      w_ff         <= w_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      bit_ff       <= bit_in;
      prod_ff      <= prod_in;
      res_idx_ff   <= res_idx_in;
      res_found_ff <= res_found_in;
      res_rej_ff   <= res_rej_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
      rsp_rej_ff   <= rsp_rej_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chosen_index   = rsp_idx_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_receiver_count = rsp_count_ff;
   assign rsp_rejected       = rsp_rej_ff;

endmodule

// ----- src/wrd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrd_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module wrd_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/wrd_useq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrd_useq
// microprogram sequencer: step counter, control store and branch select
// ----------------------------------------------------------------------------
module wrd_useq import wrd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ucode_type ctrl
);

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   ucode_type        word;
   logic             taken;

   assign word = ucode_rom(upc_ff);
   assign ctrl = word;

   always_comb begin
      case (word.cond)
         C_NEVER:     taken = 1'b0;
         C_ALWAYS:    taken = 1'b1;
         C_NO_ACCEPT: taken = flags.no_accept;
         C_PICK:      taken = flags.pick;
         C_FULL:      taken = flags.full;
         C_WT_OK:     taken = flags.wt_ok;
         C_DIV_MORE:  taken = flags.div_more;
         C_IDX_END:   taken = flags.idx_end;
         C_HIT:       taken = flags.hit;
         C_OUT_FREE:  taken = flags.out_free;
         default:     taken = 1'b0;
      endcase
      upc_in = taken ? word.target : upc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= U_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ----- src/wrd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrd_checker
// port-level checks on the dispatcher, bound to the top level
// ----------------------------------------------------------------------------
`include "weighted_random_dispatcher_assert.svh"

module wrd_checker import wrd_pkg::*; #(
   parameter int MAX_RECEIVERS = MAX_RECEIVERS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [INDEX_OUT_W-1:0] rsp_chosen_index,
   input logic                   rsp_found,
   input logic [COUNT_OUT_W-1:0] rsp_receiver_count,
   input logic                   rsp_rejected
);

   localparam logic [COUNT_OUT_W-1:0] FULL_OUT = COUNT_OUT_W'(MAX_RECEIVERS);

   // a stalled result beat holds
   `WRD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_chosen_index) && $stable(rsp_found)
      && $stable(rsp_receiver_count) && $stable(rsp_rejected),
      "stalled result beat changed")

   `WRD_ASSERT_NOW(a_found_not_rej, rsp_valid && rsp_found, !rsp_rejected,
      "result both found and rejected")

   `WRD_ASSERT_NOW(a_miss_idx_zero, rsp_valid && !rsp_found, rsp_chosen_index == '0,
      "index not zero without a selection")

   `WRD_ASSERT_NOW(a_rej_full, rsp_valid && rsp_rejected, rsp_receiver_count == FULL_OUT,
      "add rejected while table not full")

   // one request at a time: busy right after an accepted beat
   `WRD_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready,
      "request taken on back-to-back cycles")

endmodule

bind weighted_random_dispatcher wrd_checker #(
   .MAX_RECEIVERS (MAX_RECEIVERS)
) u_wrd_checker (.*);
